// File: rtl/abs_pkg.sv
`default_nettype none

package abs_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_COUNT_BITS   = 24;

  localparam int SAMPLE_W   = 16;
  localparam int OUT_CNT_W  = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CHCNT_W    = 4;
  localparam int THRESH_W   = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 4'd1;

  localparam logic [CHCNT_W-1:0]  CHCNT_RESET  = 4'd2;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd16384;

  localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;

  localparam logic [SAMPLE_W:0] NEAR_ZERO_LIMIT = 17'd3;
  localparam logic [SAMPLE_W:0] CLIP_LIMIT      = 17'd32767;

  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = 24'hFFFFFF;

  // Mean squares fit in 32 bits, so the root takes 16 two-bit steps.
  localparam int SQRT_STEPS = 16;

endpackage

`default_nettype wire

// File: rtl/abs_ifs.sv
`default_nettype none

interface abs_in_if import abs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface abs_out_if import abs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OUT_CNT_W-1:0]        sample_total;
  logic signed [SAMPLE_W-1:0]  min_sample;
  logic signed [SAMPLE_W-1:0]  max_sample;
  logic [SAMPLE_W-1:0]         peak_level;
  logic signed [SAMPLE_W-1:0]  mean_level;
  logic [SAMPLE_W-1:0]         rms_level;
  logic [OUT_CNT_W-1:0]        near_zero_total;
  logic [OUT_CNT_W-1:0]        clip_total;
  logic [OUT_CNT_W-1:0]        jump_total;
  logic [SAMPLE_W-1:0]         largest_jump;

  modport source (
    output valid, output sample_total, output min_sample, output max_sample,
    output peak_level, output mean_level, output rms_level, output near_zero_total,
    output clip_total, output jump_total, output largest_jump, input ready
  );
  modport sink (
    input valid, input sample_total, input min_sample, input max_sample,
    input peak_level, input mean_level, input rms_level, input near_zero_total,
    input clip_total, input jump_total, input largest_jump, output ready
  );
endinterface

interface abs_cfg_if import abs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/audio_buffer_statistics_unit.sv
// Audio buffer statistics unit.
// in_chan carries one signed sample per item, channels interleaved; the item
// flagged last_sample closes the buffer. out_chan carries one report per
// buffer: count, min, max, peak, mean, RMS and the near-zero, clip and jump
// counters. cfg_chan writes channel_count (index 0) and jump_threshold
// (index 1); it is always ready and should be used only while the unit idles.
// Each sample item is accepted in S_IDLE, then S_MUL forms the 16x16 square
// and updates the per-channel previous-sample memory, then S_SQ does the
// sum-of-squares add. in_chan.ready is low in S_MUL and S_SQ after an accept.
// After a last item, S_DIVM, S_DIVS and S_SQRT run and S_OUT loads the report;
// in_chan.ready stays low until the report is loaded: one shared
// compare-subtract unit runs the mean division, the mean-square division
// and the square root one bit per cycle.
// The report sits in an output register; while the receiver stalls, further
// samples of the next buffer are still taken, and only the next report waits
// until the register is free. Statistics clear once the report is loaded.
// Synchronous reset (rst_n low) restores channel_count 2, jump_threshold 16384
// and empty statistics; previous-sample memory needs no clearing because
// per-channel seen flags gate it.
`default_nettype none

module audio_buffer_statistics_unit import abs_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  abs_cfg_if.sink    cfg_chan,
  abs_in_if.sink     in_chan,
  abs_out_if.source  out_chan
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W  = COUNT_BITS + 16;
  localparam int SQ_W   = COUNT_BITS + 30;
  localparam int UW     = (COUNT_BITS + 2 > 20) ? COUNT_BITS + 2 : 20;
  localparam int CNT_W  = $clog2(SQ_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_DIVM = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [CHCNT_W-1:0]  chcnt_r;
  logic [THRESH_W-1:0] thresh_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] prev_rd_r;
  logic signed [SAMPLE_W-1:0] prev_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]    seen_r;
  logic [CH_W-1:0]            chan_pos_r;

  logic [COUNT_BITS-1:0]      count_acc_r;
  logic signed [SUM_W-1:0]    sum_acc_r;
  logic [SQ_W-1:0]            square_acc_r;
  logic [30:0]                prod_r;
  logic                       add_sq_r;
  logic signed [SAMPLE_W-1:0] min_acc_r;
  logic signed [SAMPLE_W-1:0] max_acc_r;
  logic [COUNT_BITS-1:0]      near_zero_acc_r;
  logic [COUNT_BITS-1:0]      clip_acc_r;
  logic [COUNT_BITS-1:0]      jump_acc_r;
  logic [THRESH_W-1:0]        largest_jump_r;

  logic [SQ_W-1:0]     dvd_r;
  logic [UW-1:0]       rem_r;
  logic [15:0]         root_r;
  logic [CNT_W-1:0]    step_r;
  logic signed [15:0]  mean_r;

  logic                       out_valid_r;
  logic [OUT_CNT_W-1:0]       out_total_r, out_near_r, out_clip_r, out_jump_r;
  logic signed [SAMPLE_W-1:0] out_min_r, out_max_r, out_mean_r;
  logic [SAMPLE_W-1:0]        out_peak_r, out_rms_r, out_ljump_r;

  logic in_acc;
  assign in_acc = in_chan.valid && (state_r == S_IDLE);

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  // Per-sample arithmetic.
  logic signed [31:0]    prod_full;
  logic [SAMPLE_W:0]     mag;
  logic signed [SAMPLE_W:0] diff_s;
  logic [SAMPLE_W:0]     delta17;
  logic [THRESH_W-1:0]   delta;
  logic [7:0]            chans;
  logic [7:0]            pos_inc;

  always_comb begin
    prod_full = sample_r * sample_r;
    mag       = sample_r[SAMPLE_W-1] ? (SAMPLE_W+1)'(-{sample_r[SAMPLE_W-1], sample_r})
                                     : {1'b0, sample_r};
    diff_s    = {sample_r[SAMPLE_W-1], sample_r} - {prev_rd_r[SAMPLE_W-1], prev_rd_r};
    delta17   = diff_s[SAMPLE_W] ? (SAMPLE_W+1)'(-diff_s) : diff_s;
    delta     = delta17[THRESH_W-1:0];
    // Zero channels counts as one; too many saturates at the channel limit.
    if (chcnt_r == '0) begin
      chans = 8'd1;
    end else if ({4'd0, chcnt_r} > 8'(MAX_CHANNELS)) begin
      chans = 8'(MAX_CHANNELS);
    end else begin
      chans = {4'd0, chcnt_r};
    end
    pos_inc = 8'(chan_pos_r) + 8'd1;
  end

  // Shared compare-subtract unit for both divisions and the square root.
  logic [UW-1:0] a_in, b_in, sub_out;
  logic          ge;

  always_comb begin
    unique case (state_r)
      S_DIVM, S_DIVS: begin
        a_in = {rem_r[UW-2:0], dvd_r[SQ_W-1]};
        b_in = {{(UW-COUNT_BITS){1'b0}}, count_acc_r};
      end
      S_SQRT: begin
        a_in = {rem_r[UW-3:0], dvd_r[SQ_W-1 -: 2]};
        b_in = {{(UW-18){1'b0}}, root_r, 2'b01};
      end
      default: begin
        a_in = '0;
        b_in = '0;
      end
    endcase
    ge      = (a_in >= b_in);
    sub_out = a_in - b_in;
  end

  logic [SQ_W-1:0]  quot;
  logic [SUM_W-1:0] sum_mag;
  logic [16:0]      amin, amax;

  always_comb begin
    quot    = {dvd_r[SQ_W-2:0], ge};
    sum_mag = sum_acc_r[SUM_W-1] ? SUM_W'(-sum_acc_r) : sum_acc_r;
    amin    = min_acc_r[SAMPLE_W-1] ? 17'(-{min_acc_r[SAMPLE_W-1], min_acc_r})
                                    : {1'b0, min_acc_r};
    amax    = max_acc_r[SAMPLE_W-1] ? 17'(-{max_acc_r[SAMPLE_W-1], max_acc_r})
                                    : {1'b0, max_acc_r};
  end

  function automatic logic [OUT_CNT_W-1:0] clamp_cnt(input logic [COUNT_BITS-1:0] v);
    logic [32:0] ext;
    begin
      ext = 33'(v);
      clamp_cnt = (ext > 33'(OUT_CNT_MAX)) ? OUT_CNT_MAX : ext[OUT_CNT_W-1:0];
    end
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + CNT_ONE;
  endfunction

  logic out_free;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SQ;
      S_SQ:   state_nxt = last_r ? S_DIVM : S_IDLE;
      S_DIVM: if (step_r == CNT_W'(SQ_W - 1)) state_nxt = S_DIVS;
      S_DIVS: if (step_r == CNT_W'(SQ_W - 1)) state_nxt = S_SQRT;
      S_SQRT: if (step_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Previous sample per channel; read on accept, written the cycle after.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_rd_r <= prev_mem[chan_pos_r];
    end
    if (state_r == S_MUL) begin
      prev_mem[chan_pos_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_chan.sample;
      last_r   <= in_chan.last_sample;
    end
    if (state_r == S_MUL) begin
      prod_r <= prod_full[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chcnt_r  <= CHCNT_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_CHANNEL_COUNT:  chcnt_r  <= cfg_chan.data[CHCNT_W-1:0];
        CFG_JUMP_THRESHOLD: thresh_r <= cfg_chan.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      seen_r          <= '0;
      chan_pos_r      <= '0;
      count_acc_r     <= '0;
      sum_acc_r       <= '0;
      square_acc_r    <= '0;
      add_sq_r        <= 1'b0;
      min_acc_r       <= MIN_RESET;
      max_acc_r       <= MAX_RESET;
      near_zero_acc_r <= '0;
      clip_acc_r      <= '0;
      jump_acc_r      <= '0;
      largest_jump_r  <= '0;
      step_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // In S_OUT a taken report is replaced by the next one below.
      if (out_valid_r && out_chan.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_MUL: begin
          // Sum and square stop once the count has saturated.
          add_sq_r <= (count_acc_r != COUNT_MAX);
          if (count_acc_r != COUNT_MAX) begin
            sum_acc_r <= sum_acc_r + {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
          end
          count_acc_r <= sat_inc(count_acc_r);
          if (sample_r < min_acc_r) min_acc_r <= sample_r;
          if (sample_r > max_acc_r) max_acc_r <= sample_r;
          if (mag <= NEAR_ZERO_LIMIT) near_zero_acc_r <= sat_inc(near_zero_acc_r);
          if (mag >= CLIP_LIMIT) clip_acc_r <= sat_inc(clip_acc_r);
          if (seen_r[chan_pos_r] && (delta > thresh_r)) begin
            jump_acc_r <= sat_inc(jump_acc_r);
            if (delta > largest_jump_r) largest_jump_r <= delta;
          end
          seen_r[chan_pos_r] <= 1'b1;
          chan_pos_r <= (pos_inc >= chans) ? '0 : chan_pos_r + CH_W'(1);
        end
        S_SQ: begin
          if (add_sq_r) begin
            square_acc_r <= square_acc_r + {{(SQ_W-31){1'b0}}, prod_r};
          end
          dvd_r  <= {{(SQ_W-SUM_W){1'b0}}, sum_mag};
          rem_r  <= '0;
          step_r <= '0;
        end
        S_DIVM, S_DIVS: begin
          if (step_r == CNT_W'(SQ_W - 1)) begin
            rem_r  <= '0;
            step_r <= '0;
            if (state_r == S_DIVM) begin
              mean_r <= sum_acc_r[SUM_W-1] ? 16'(-quot[15:0]) : quot[15:0];
              dvd_r  <= square_acc_r;
            end else begin
              dvd_r  <= {quot[31:0], {(SQ_W-32){1'b0}}};
              root_r <= '0;
            end
          end else begin
            rem_r  <= ge ? sub_out : a_in;
            dvd_r  <= quot;
            step_r <= step_r + CNT_W'(1);
          end
        end
        S_SQRT: begin
          rem_r  <= ge ? sub_out : a_in;
          dvd_r  <= {dvd_r[SQ_W-3:0], 2'b00};
          root_r <= {root_r[14:0], ge};
          step_r <= step_r + CNT_W'(1);
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_total_r     <= clamp_cnt(count_acc_r);
            out_min_r       <= min_acc_r;
            out_max_r       <= max_acc_r;
            out_peak_r      <= (amin > amax) ? amin[15:0] : amax[15:0];
            out_mean_r      <= mean_r;
            out_rms_r       <= root_r;
            out_near_r      <= clamp_cnt(near_zero_acc_r);
            out_clip_r      <= clamp_cnt(clip_acc_r);
            out_jump_r      <= clamp_cnt(jump_acc_r);
            out_ljump_r     <= largest_jump_r;
            seen_r          <= '0;
            chan_pos_r      <= '0;
            count_acc_r     <= '0;
            sum_acc_r       <= '0;
            square_acc_r    <= '0;
            min_acc_r       <= MIN_RESET;
            max_acc_r       <= MAX_RESET;
            near_zero_acc_r <= '0;
            clip_acc_r      <= '0;
            jump_acc_r      <= '0;
            largest_jump_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.sample_total    = out_total_r;
  assign out_chan.min_sample      = out_min_r;
  assign out_chan.max_sample      = out_max_r;
  assign out_chan.peak_level      = out_peak_r;
  assign out_chan.mean_level      = out_mean_r;
  assign out_chan.rms_level       = out_rms_r;
  assign out_chan.near_zero_total = out_near_r;
  assign out_chan.clip_total      = out_clip_r;
  assign out_chan.jump_total      = out_jump_r;
  assign out_chan.largest_jump    = out_ljump_r;

endmodule

`default_nettype wire

// File: rtl/abs_checker.sv
`default_nettype none

module abs_checker import abs_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [OUT_CNT_W-1:0]       out_total,
  input wire logic signed [SAMPLE_W-1:0] out_min,
  input wire logic signed [SAMPLE_W-1:0] out_max,
  input wire logic [SAMPLE_W-1:0]        out_peak
);

  // An accepted sample keeps the unit busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_total, out_min, out_max, out_peak}))
    else $error("stalled report changed or dropped");

  // A report always covers at least one sample, so min cannot exceed max.
  a_report_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total != '0) && (out_min <= out_max))
    else $error("report with empty count or min above max");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid after reset");

endmodule

bind audio_buffer_statistics_unit abs_checker u_abs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_total (out_chan.sample_total),
  .out_min   (out_chan.min_sample),
  .out_max   (out_chan.max_sample),
  .out_peak  (out_chan.peak_level)
);

`default_nettype wire
